### design/stack_arithmetic_engine_assert.svh
// Assertion macros for the stack arithmetic engine
`ifndef STACK_ARITHMETIC_ENGINE_ASSERT_SVH
`define STACK_ARITHMETIC_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SAE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SAE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SAE_ASSERT_IMPL(label, clk, rst_n, prop)
`define SAE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### design/sae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sae_pkg;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int WORD_WIDTH_DEF  = 32;
    localparam int IO_WIDTH        = 32;
    localparam int KIND_W          = 3;
    localparam int INDEX_W         = 10;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 11;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH = 3'd0, OP_POP = 3'd1, OP_PEEK_TOP = 3'd2, OP_PEEK_BOT = 3'd3,
        OP_ADD = 3'd4, OP_SUB = 3'd5, OP_MUL = 3'd6, OP_DIV = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_RANGE = 3'd3,
        ST_FEW = 3'd4, ST_DIVZ = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD_TOP, S_RD_SEC, S_WAIT, S_EXEC, S_DIV, S_WRITE, S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;    // capture input item
        logic rd_top;       // read address = count-1 (or peek / pop address)
        logic rd_sec;       // read address = count-2
        logic cap_top;      // capture read data as top operand
        logic cap_sec;      // capture read data as second operand
        logic exec;         // compute add/sub/mul/push/pop/peek result
        logic div_start;
        logic write_mem;    // write result word
        logic finish;       // load output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic     needs_mem;   // op reads the stack
        logic     is_binary;
        logic     is_div;
        logic     err;         // precondition failed
        logic     div_zero;    // captured top operand is zero
        logic     div_done;
        logic     out_busy;    // output register occupied
    } dp_stat_t;
endpackage
`default_nettype wire

### design/sae_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring floor divider, one quotient bit per cycle
module sae_divider #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [WORD_WIDTH-1:0] num,
    input  wire logic [WORD_WIDTH-1:0] den,
    output logic                       done,
    output logic [WORD_WIDTH-1:0]      quot
);
    import sae_pkg::*;
    localparam int CW = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] q_reg, q_next;
    logic [WORD_WIDTH:0]   r_reg, r_next;
    logic [WORD_WIDTH-1:0] d_reg, d_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  neg_reg, neg_next;
    logic                  sat_reg, sat_next;
    logic                  done_reg, done_next;
    logic [WORD_WIDTH-1:0] num_abs, den_abs;
    logic [WORD_WIDTH:0]   shifted, trial;
    logic [WORD_WIDTH-1:0] q_mag;
    logic                  rem_nz;

    always_comb begin
        num_abs = num[WORD_WIDTH-1] ? (~num + 1'b1) : num;
        den_abs = den[WORD_WIDTH-1] ? (~den + 1'b1) : den;
        shifted = {r_reg[WORD_WIDTH-1:0], q_reg[WORD_WIDTH-1]};
        trial   = shifted - {1'b0, d_reg};
        q_next  = q_reg;
        r_next  = r_reg;
        d_next  = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        sat_next = sat_reg;
        done_next = 1'b0;
        if (start) begin
            q_next   = num_abs;
            r_next   = '0;
            d_next   = den_abs;
            cnt_next = CW'(WORD_WIDTH);
            busy_next = 1'b1;
            neg_next = num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
            sat_next = (num == {1'b1, {(WORD_WIDTH-1){1'b0}}}) && (&den);
        end else if (busy_reg) begin
            if (!trial[WORD_WIDTH]) begin
                r_next = trial;
                q_next = {q_reg[WORD_WIDTH-2:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[WORD_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
    end

    // Sign fix-up: saturate, or negate less one if rem nonzero
    always_comb begin
        q_mag  = q_reg;
        rem_nz = |r_reg;
        if (sat_reg) quot = {1'b0, {(WORD_WIDTH-1){1'b1}}};
        else if (neg_reg) quot = (~q_mag + 1'b1) - {{(WORD_WIDTH-1){1'b0}}, rem_nz};
        else quot = q_mag;
    end
    assign done = done_reg;
endmodule
`default_nettype wire

### design/sae_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stack_arithmetic_engine_assert.svh"
// Stack memory, depth counter, ALU and output register
module sae_datapath #(
    parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = sae_pkg::WORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sae_pkg::dp_cmd_t              cmd,
    output sae_pkg::dp_stat_t                  stat,
    input  wire logic [sae_pkg::KIND_W-1:0]    in_kind,
    input  wire logic [sae_pkg::IO_WIDTH-1:0]  in_value,
    input  wire logic [sae_pkg::INDEX_W-1:0]   in_index,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sae_pkg::IO_WIDTH-1:0]       out_result,
    output logic [sae_pkg::STATUS_W-1:0]       out_status,
    output logic [sae_pkg::DEPTH_W-1:0]        out_depth
);
    import sae_pkg::*;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] rdata_reg;
    logic [CW-1:0]         count_reg, count_next;
    op_t                   kind_reg;
    logic [WORD_WIDTH-1:0] value_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [WORD_WIDTH-1:0] top_reg, sec_reg, res_reg, res_next;
    status_t               st_reg, st_next;
    logic [CW-1:0]         rd_addr_full;
    logic [CW-1:0]         idx_ext;
    logic [2*WORD_WIDTH-1:0] prod;
    logic [WORD_WIDTH-1:0] quot;
    logic                  div_done;
    logic                  ov_reg;
    logic [IO_WIDTH-1:0]   res_out_reg;
    logic [STATUS_W-1:0]   st_out_reg;
    logic [DEPTH_W-1:0]    dep_out_reg;

    // Operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg  <= op_t'(in_kind);
            value_reg <= WORD_WIDTH'($signed(in_value));
            index_reg <= in_index;
        end
        if (cmd.cap_top) top_reg <= rdata_reg;
        if (cmd.cap_sec) sec_reg <= rdata_reg;
    end

    assign idx_ext = CW'(index_reg);

    // Precondition checks
    always_comb begin
        stat.needs_mem = (kind_reg != OP_PUSH);
        stat.is_binary = kind_reg[2];
        stat.is_div    = (kind_reg == OP_DIV);
        unique case (kind_reg)
            OP_PUSH:              stat.err = (count_reg >= CW'(STACK_DEPTH));
            OP_POP:               stat.err = (count_reg == '0);
            OP_PEEK_TOP, OP_PEEK_BOT: stat.err = ({1'b0, idx_ext} >= {1'b0, count_reg});
            default:              stat.err = (count_reg < CW'(2));
        endcase
        stat.div_zero = (top_reg == '0);
        stat.div_done = div_done;
        stat.out_busy = out_valid;
    end

    // Read address
    always_comb begin
        unique case (kind_reg)
            OP_PEEK_TOP: rd_addr_full = count_reg - 1'b1 - idx_ext;
            OP_PEEK_BOT: rd_addr_full = idx_ext;
            default:     rd_addr_full = cmd.rd_sec ? count_reg - CW'(2) : count_reg - 1'b1;
        endcase
    end

    // Stack memory with registered read; writes go to the current depth
    always_ff @(posedge aclk) begin
        if (cmd.write_mem) mem[AW'(count_reg)] <= res_reg;
        if (cmd.rd_top || cmd.rd_sec) rdata_reg <= mem[AW'(rd_addr_full)];
    end

    assign prod = top_reg * sec_reg;

    sae_divider #(.WORD_WIDTH(WORD_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(sec_reg), .den(top_reg), .done(div_done), .quot(quot)
    );

    // Result and status
    always_comb begin
        res_next   = res_reg;
        st_next    = st_reg;
        count_next = count_reg;
        if (cmd.exec) begin
            res_next = '0;
            st_next  = ST_OK;
            if (stat.err) begin
                unique case (kind_reg)
                    OP_PUSH:                  st_next = ST_FULL;
                    OP_POP:                   st_next = ST_EMPTY;
                    OP_PEEK_TOP, OP_PEEK_BOT: st_next = ST_RANGE;
                    default:                  st_next = ST_FEW;
                endcase
            end else begin
                unique case (kind_reg)
                    OP_PUSH: res_next = value_reg;
                    OP_POP: begin
                        res_next   = top_reg;
                        count_next = count_reg - 1'b1;
                    end
                    OP_PEEK_TOP, OP_PEEK_BOT: res_next = top_reg;
                    OP_ADD: res_next = sec_reg + top_reg;
                    OP_SUB: res_next = sec_reg - top_reg;
                    OP_MUL: res_next = prod[WORD_WIDTH-1:0];
                    default: begin
                        res_next = '0;
                        if (top_reg == '0) st_next = ST_DIVZ;
                    end
                endcase
                if (stat.is_binary) count_next = count_reg - CW'(2);
            end
        end
        if (div_done) res_next = quot;
        if (cmd.write_mem) count_next = count_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else          count_reg <= count_next;
        res_reg <= res_next;
        st_reg  <= st_next;
    end

    // Output register; push shows zero in result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.finish) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
        if (cmd.finish) begin
            res_out_reg <= (kind_reg == OP_PUSH) ? '0 : IO_WIDTH'(res_reg);
            st_out_reg  <= st_reg;
            dep_out_reg <= DEPTH_W'(count_reg);
        end
    end

    assign out_valid  = ov_reg;
    assign out_result = res_out_reg;
    assign out_status = st_out_reg;
    assign out_depth  = dep_out_reg;

    `SAE_ASSERT_IMPL(a_count_bound, aclk, aresetn, count_reg <= CW'(STACK_DEPTH))
    `SAE_ASSERT_IMPL(a_no_write_full, aclk, aresetn,
        cmd.write_mem |-> count_reg < CW'(STACK_DEPTH))
    `SAE_ASSERT_IMPL(a_finish_free, aclk, aresetn, cmd.finish |-> !out_valid)
endmodule
`default_nettype wire

### design/sae_controller.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stack_arithmetic_engine_assert.svh"
// Sequencer for one item at a time
module sae_controller (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output sae_pkg::dp_cmd_t       cmd,
    input  wire sae_pkg::dp_stat_t stat
);
    import sae_pkg::*;
    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_CHECK;
            S_CHECK:  begin
                if (stat.err || !stat.needs_mem) state_next = S_EXEC;
                else state_next = S_RD_TOP;
            end
            S_RD_TOP: state_next = stat.is_binary ? S_RD_SEC : S_WAIT;
            S_RD_SEC: state_next = S_WAIT;
            S_WAIT:   state_next = stat.is_binary ? S_EXEC : S_EXEC;
            S_EXEC: begin
                if (stat.err) state_next = S_OUT;
                else if (stat.is_div && stat.div_zero) state_next = S_OUT;
                else if (stat.is_div) state_next = S_DIV;
                else if (stat.is_binary || !stat.needs_mem) state_next = S_WRITE;
                else state_next = S_OUT;
            end
            S_DIV:    if (stat.div_done) state_next = S_WRITE;
            S_WRITE:  state_next = S_OUT;
            S_OUT:    if (!stat.out_busy) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs; top lands in S_RD_SEC (unary: S_WAIT), second S_WAIT
    always_comb begin
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:   cmd.load_item = in_valid;
            S_RD_TOP: cmd.rd_top = 1'b1;
            S_RD_SEC: begin
                cmd.rd_sec  = 1'b1;
                cmd.cap_top = 1'b1;
            end
            S_WAIT:   begin
                if (stat.is_binary) cmd.cap_sec = 1'b1;
                else cmd.cap_top = 1'b1;
            end
            S_EXEC:   begin
                cmd.exec      = 1'b1;
                cmd.div_start = stat.is_div && !stat.err && !stat.div_zero;
            end
            S_WRITE:  cmd.write_mem = 1'b1;
            S_OUT:    cmd.finish = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

    // State register; divide by zero skips the divider and the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SAE_ASSERT_IMPL(a_one_item, aclk, aresetn, in_ready |-> state_reg == S_IDLE)
    `SAE_ASSERT_IMPL(a_exec_once, aclk, aresetn, cmd.exec |=> !cmd.exec)
    `SAE_ASSERT_IMPL(a_write_after, aclk, aresetn,
        cmd.write_mem |-> $past(state_reg) == S_EXEC || $past(state_reg) == S_DIV)
endmodule
`default_nettype wire

### design/stack_arithmetic_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Content
// s_axis  | in  | tdata: kind[2:0], value[34:3], index[44:35]
// m_axis  | out | tdata: result[31:0], status[34:32], depth[45:35]
// An item passes from acceptance to the next ready through check, reads,
// execute, write and output as its op needs; a divide waits on the shift divider.
// Reset (aresetn low, synchronous) empties the stack; memory is not cleared.
// A held result in the output register stalls only the next item's end.
module stack_arithmetic_engine #(
    parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = sae_pkg::WORD_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // kind, value, index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // result, status, depth
);
    import sae_pkg::*;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [IO_WIDTH-1:0] res;
    logic [STATUS_W-1:0] st;
    logic [DEPTH_W-1:0]  dep;

    sae_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .cmd(cmd), .stat(stat)
    );

    sae_datapath #(.STACK_DEPTH(STACK_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_kind(s_axis_tdata[2:0]), .in_value(s_axis_tdata[34:3]),
        .in_index(s_axis_tdata[44:35]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_result(res), .out_status(st), .out_depth(dep)
    );

    assign m_axis_tdata = {2'b00, dep, st, res};
endmodule
`default_nettype wire

### dv/stack_arithmetic_engine_checker.sv
`timescale 1ns / 1ps
module stack_arithmetic_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // kind[2:0], value[34:3], index[44:35]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // result[31:0], status[34:32], depth[45:35]
    output int          fail_count,
    output int          pending
);
    import sae_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        status_t     code;
        logic [10:0] level;
    } answer_t;

    logic signed [31:0] stack_mem [0:STACK_DEPTH_DEF-1];
    int unsigned        entries;
    answer_t            answers_due [$];

    assign pending = answers_due.size();

    // Floor division with the most-negative by minus-one saturation
    function automatic logic [31:0] floor_quotient(logic signed [31:0] num,
                                                   logic signed [31:0] den);
        longint a;
        longint b;
        longint q;
        a = num;
        b = den;
        if (b == -1 && a == -64'sd2147483648) return 32'h7fffffff;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
        return q[31:0];
    endfunction

    // Apply one operation to the shadow stack and return the answer it gives
    function automatic answer_t stack_apply(op_t op, logic [31:0] val, logic [9:0] idx);
        answer_t a;
        logic signed [31:0] top;
        logic signed [31:0] sec;
        a.word = '0;
        a.code = ST_OK;
        case (op)
            OP_PUSH: begin
                if (entries >= STACK_DEPTH_DEF) a.code = ST_FULL;
                else begin
                    stack_mem[entries] = val;
                    entries++;
                end
            end
            OP_POP: begin
                if (entries == 0) a.code = ST_EMPTY;
                else begin
                    entries--;
                    a.word = stack_mem[entries];
                end
            end
            OP_PEEK_TOP, OP_PEEK_BOT: begin
                if (idx >= entries) a.code = ST_RANGE;
                else if (op == OP_PEEK_TOP) a.word = stack_mem[entries - 1 - idx];
                else a.word = stack_mem[idx];
            end
            default: begin
                if (entries < 2) a.code = ST_FEW;
                else begin
                    top = stack_mem[entries - 1];
                    sec = stack_mem[entries - 2];
                    entries -= 2;
                    case (op)
                        OP_ADD: a.word = sec + top;
                        OP_SUB: a.word = sec - top;
                        OP_MUL: a.word = sec * top;
                        default: begin
                            if (top == 0) a.code = ST_DIVZ;
                            else a.word = floor_quotient(sec, top);
                        end
                    endcase
                    if (a.code == ST_OK) begin
                        stack_mem[entries] = a.word;
                        entries++;
                    end
                end
            end
        endcase
        a.level = entries[10:0];
        return a;
    endfunction

    // Predict on accepted input items, compare accepted results
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        int      errs;
        errs = 0;
        if (!aresetn) begin
            entries = 0;
            answers_due.delete();
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                answers_due.push_back(stack_apply(op_t'(s_axis_tdata[2:0]),
                                                  s_axis_tdata[34:3], s_axis_tdata[44:35]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.word  = m_axis_tdata[31:0];
                got.code  = status_t'(m_axis_tdata[34:32]);
                got.level = m_axis_tdata[45:35];
                if (answers_due.size() == 0) begin
                    $error("result item with nothing expected");
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.word !== want.word) begin
                        $error("result: expected %0d actual %0d",
                               $signed(want.word), $signed(got.word));
                        errs++;
                    end
                    if (got.code !== want.code) begin
                        $error("status: expected %0d actual %0d", want.code, got.code);
                        errs++;
                    end
                    if (got.level !== want.level) begin
                        $error("depth: expected %0d actual %0d", want.level, got.level);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end
endmodule

### dv/stack_arithmetic_engine_tb.sv
`timescale 1ns / 1ps
module stack_arithmetic_engine_tb;
    import sae_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // kind[2:0], value[34:3], index[44:35]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // result[31:0], status[34:32], depth[45:35]
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          depth_model;
    bit          calm;

    stack_arithmetic_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    stack_arithmetic_engine_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: cycles with no item moving on either channel
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side stalls in bursts
    initial begin
        m_axis_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    end

    // Random value with frequent corner words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'h0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Drive one item, with an optional gap before it; valid stays high until
    // the next item or gap replaces it
    task automatic send_op(op_t op, logic [31:0] val, logic [9:0] idx);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, idx, val, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        case (op)
            OP_PUSH: if (depth_model < STACK_DEPTH_DEF) depth_model++;
            OP_POP:  if (depth_model > 0) depth_model--;
            OP_PEEK_TOP, OP_PEEK_BOT: ;
            default: if (depth_model >= 2) depth_model--;
        endcase
    endtask

    initial begin
        op_t op;
        int  n;
        int  k;
        calm = 1'b0;
        depth_model = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: errors on empty stack, then every operation and corner
        send_op(OP_POP, 0, 0);
        send_op(OP_PEEK_TOP, 0, 0);
        send_op(OP_ADD, 0, 0);
        send_op(OP_PUSH, 32'h80000000, 10'h3ff);
        send_op(OP_DIV, 0, 0);
        send_op(OP_PUSH, 32'hffffffff, 0);
        send_op(OP_PEEK_BOT, 0, 10'd1);
        send_op(OP_PEEK_BOT, 0, 10'd2);
        send_op(OP_PEEK_TOP, 0, 10'h3ff);
        send_op(OP_DIV, 0, 0);
        send_op(OP_PUSH, 32'h7fffffff, 0);
        send_op(OP_PUSH, 32'h0, 0);
        send_op(OP_DIV, 0, 0);
        send_op(OP_PUSH, -32'sd7, 0);
        send_op(OP_PUSH, 32'd2, 0);
        send_op(OP_DIV, 0, 0);
        send_op(OP_PUSH, 32'h7fffffff, 0);
        send_op(OP_ADD, 0, 0);
        send_op(OP_PUSH, 32'h80000000, 0);
        send_op(OP_SUB, 0, 0);
        send_op(OP_PUSH, 32'h10000, 0);
        send_op(OP_MUL, 0, 0);
        send_op(OP_POP, 0, 0);
        send_op(OP_POP, 0, 0);

        // Random: mostly push-then-compute sequences, small depth
        for (n = 0; n < 376; n++) begin
            if (n == 320) calm = 1'b1;
            k = $urandom_range(0, 9);
            if (k < 4 && depth_model < 12) op = OP_PUSH;
            else if (k < 6) op = op_t'($urandom_range(4, 7));
            else op = op_t'($urandom_range(0, 7));
            if (op == OP_PEEK_TOP || op == OP_PEEK_BOT)
                send_op(op, $urandom,
                        ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, depth_model)));
            else
                send_op(op, pick_word(), 10'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
